### rtl/cbp_pkg.sv
// Shared types and constants for the circle boundary projection block.
package cbp_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned RadiusW   = 31;
  localparam int unsigned DeltaW    = 33;
  localparam int unsigned MagW      = 32;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned RadicandW = 66;
  localparam int unsigned RootW     = 33;
  localparam int unsigned RemW      = 35;
  localparam int unsigned DremW     = 33;
  localparam int unsigned ResW      = 34;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned ApbDataW  = 32;

  localparam int unsigned RootSteps = 33;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned CntW      = 6;

  localparam logic signed [CoordW-1:0] CentreReset = '0;
  localparam logic [RadiusW-1:0]       RadiusReset = 31'd65536;

  typedef enum logic [1:0] {
    REG_CENTRE_X = 2'd0,
    REG_CENTRE_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_SQX   = 4'd2,
    OP_SQY   = 4'd3,
    OP_SUM   = 4'd4,
    OP_ROOT  = 4'd5,
    OP_PASS  = 4'd6,
    OP_MULX  = 4'd7,
    OP_MULY  = 4'd8,
    OP_DINIT = 4'd9,
    OP_DIV   = 4'd10,
    OP_RESX  = 4'd11,
    OP_RESY  = 4'd12,
    OP_OUT   = 4'd13
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic out_free;
  } stat_t;

endpackage

### rtl/cbp_ctrl.sv
// Sequencer for the circle boundary projection datapath.
module cbp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cbp_pkg::stat_t stat_i,
  output cbp_pkg::cmd_t  cmd_o
);
  import cbp_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_SQX  = 15'h0002,
    S_SQY  = 15'h0004,
    S_SUM  = 15'h0008,
    S_ROOT = 15'h0010,
    S_CMP  = 15'h0020,
    S_MULX = 15'h0040,
    S_DINX = 15'h0080,
    S_DIVX = 15'h0100,
    S_RESX = 15'h0200,
    S_MULY = 15'h0400,
    S_DINY = 15'h0800,
    S_DIVY = 15'h1000,
    S_RESY = 15'h2000,
    S_DONE = 15'h4000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_SQX;
        end
      end
      S_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        cnt_d    = '0;
        state_d  = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootSteps - 1)) state_d = S_CMP;
      end
      S_CMP: begin
        if (stat_i.outside) begin
          state_d = S_MULX;
        end else begin
          cmd_o.op = OP_PASS;
          state_d  = S_DONE;
        end
      end
      S_MULX: begin
        cmd_o.op = OP_MULX;
        state_d  = S_DINX;
      end
      S_DINX: begin
        cmd_o.op = OP_DINIT;
        cnt_d    = '0;
        state_d  = S_DIVX;
      end
      S_DIVX: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_RESX;
      end
      S_RESX: begin
        cmd_o.op = OP_RESX;
        state_d  = S_MULY;
      end
      S_MULY: begin
        cmd_o.op = OP_MULY;
        state_d  = S_DINY;
      end
      S_DINY: begin
        cmd_o.op = OP_DINIT;
        cnt_d    = '0;
        state_d  = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_RESY;
      end
      S_RESY: begin
        cmd_o.op = OP_RESY;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register can take it
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/cbp_dp.sv
// Datapath: shared multiplier, bit-serial square root and divider, output register.
module cbp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbp_pkg::cmd_t       cmd_i,
  output cbp_pkg::stat_t      stat_o,
  input  logic signed [31:0]  centre_x_i,
  input  logic signed [31:0]  centre_y_i,
  input  logic [30:0]         circle_radius_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic                last_point_i,
  output logic signed [31:0]  new_x_o,
  output logic signed [31:0]  new_y_o,
  output logic                moved_o,
  output logic                population_inside_o,
  output logic                end_of_population_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  import cbp_pkg::*;

  function automatic logic [CoordW-1:0] sat_coord(logic signed [ResW-1:0] v);
    logic signed [ResW-1:0] hi;
    logic signed [ResW-1:0] lo;
    hi = ResW'(signed'({1'b0, {(CoordW-1){1'b1}}}));
    lo = -hi - ResW'(1);
    if (v > hi) return {1'b0, {(CoordW-1){1'b1}}};
    if (v < lo) return {1'b1, {(CoordW-1){1'b0}}};
    return v[CoordW-1:0];
  endfunction

  logic signed [CoordW-1:0] px_q, py_q;
  logic                     last_q;
  logic [MagW-1:0]          ax_q, ay_q;
  logic                     negx_q, negy_q;
  logic [ProdW-1:0]         prod_q;
  logic [RadicandW-1:0]     acc_q;
  logic [RemW-1:0]          rem_q;
  logic [RootW-1:0]         root_q;
  logic [DremW-1:0]         drem_q;
  logic [MagW-1:0]          dq_q;
  logic [CoordW-1:0]        resx_q, resy_q;
  logic [CoordW-1:0]        outx_q, outy_q;
  logic                     moved_q, popin_q, eop_q, out_valid_q;
  logic                     all_inside_q;

  logic signed [DeltaW-1:0] dx, dy, dx_abs, dy_abs;
  logic [MagW-1:0]          mul_a, mul_b;
  logic [ProdW-1:0]         mul_p;
  logic [RemW:0]            rem_sh, trial, rem_sub;
  logic                     root_ge;
  logic [DremW:0]           div_t, div_d, div_sub;
  logic                     div_ge;
  logic signed [ResW-1:0]   q_ext, res_off_x, res_off_y, res_x, res_y;
  logic                     outside;

  // differences are exact in 33 bits; magnitudes fit in 32
  assign dx     = DeltaW'(point_x_i) - DeltaW'(centre_x_i);
  assign dy     = DeltaW'(point_y_i) - DeltaW'(centre_y_i);
  assign dx_abs = dx[DeltaW-1] ? -dx : dx;
  assign dy_abs = dy[DeltaW-1] ? -dy : dy;

  always_comb begin
    mul_a = ax_q;
    mul_b = ax_q;
    case (cmd_i.op)
      OP_SQY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      OP_MULX: begin
        mul_a = MagW'(circle_radius_i);
        mul_b = ax_q;
      end
      OP_MULY: begin
        mul_a = MagW'(circle_radius_i);
        mul_b = ay_q;
      end
      default: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one result bit per step from the top two radicand bits
  assign rem_sh  = {rem_q[RemW-2:0], acc_q[RadicandW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign root_ge = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // restoring division by d = root_q; the remainder stays below d
  assign div_t   = {drem_q, dq_q[MagW-1]};
  assign div_d   = {1'b0, root_q};
  assign div_ge  = div_t >= div_d;
  assign div_sub = div_t - div_d;

  assign q_ext     = ResW'(dq_q);
  assign res_off_x = negx_q ? -q_ext : q_ext;
  assign res_off_y = negy_q ? -q_ext : q_ext;
  assign res_x     = ResW'(centre_x_i) + res_off_x;
  assign res_y     = ResW'(centre_y_i) + res_off_y;

  assign outside = root_q > RootW'(circle_radius_i);

  assign stat_o.outside  = outside;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        px_q   <= point_x_i;
        py_q   <= point_y_i;
        last_q <= last_point_i;
        ax_q   <= dx_abs[MagW-1:0];
        ay_q   <= dy_abs[MagW-1:0];
        negx_q <= dx[DeltaW-1];
        negy_q <= dy[DeltaW-1];
      end
      OP_SQX, OP_MULX, OP_MULY: begin
        prod_q <= mul_p;
      end
      OP_SQY: begin
        acc_q  <= RadicandW'(prod_q);
        prod_q <= mul_p;
      end
      OP_SUM: begin
        acc_q  <= acc_q + RadicandW'(prod_q);
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_ROOT: begin
        acc_q  <= {acc_q[RadicandW-3:0], 2'b00};
        rem_q  <= root_ge ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
        root_q <= {root_q[RootW-2:0], root_ge};
      end
      OP_PASS: begin
        resx_q <= px_q;
        resy_q <= py_q;
      end
      OP_DINIT: begin
        // product is below 2^63 and its upper half below d
        drem_q <= DremW'(prod_q[ProdW-2:MagW]);
        dq_q   <= prod_q[MagW-1:0];
      end
      OP_DIV: begin
        drem_q <= div_ge ? div_sub[DremW-1:0] : div_t[DremW-1:0];
        dq_q   <= {dq_q[MagW-2:0], div_ge};
      end
      OP_RESX: begin
        resx_q <= sat_coord(res_x);
      end
      OP_RESY: begin
        resy_q <= sat_coord(res_y);
      end
      OP_OUT: begin
        outx_q  <= resx_q;
        outy_q  <= resy_q;
        moved_q <= outside;
        popin_q <= last_q && all_inside_q && !outside;
        eop_q   <= last_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      all_inside_q <= 1'b1;
    end else begin
      if (cmd_i.op == OP_OUT) begin
        out_valid_q  <= 1'b1;
        all_inside_q <= last_q ? 1'b1 : (all_inside_q && !outside);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign new_x_o             = outx_q;
  assign new_y_o             = outy_q;
  assign moved_o             = moved_q;
  assign population_inside_o = popin_q;
  assign end_of_population_o = eop_q;
  assign out_valid_o         = out_valid_q;

endmodule

### rtl/circle_boundary_projection_top.sv
// Top level: register port, sequencer and datapath of the disk clamp.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_ready_o point_x_i, point_y_i, last_point_i
//   out      output     out_valid_o/out_ready_i new_x_o, new_y_o, moved_o,
//                                             population_inside_o, end_of_population_o
//   cfg      input      APB psel/penable      paddr, pwdata, prdata
//
// An item inside the disk runs the 33-step square root before its result; an item
// outside also runs two 32-step divisions. The root and the divisions run one bit
// per cycle, each in its own bit-serial registers.
// One item is worked on at a time; the next is accepted once the result is in
// the output register, even while that result waits on out_ready_i.
// Reset clears control state and out_valid_o, sets the all-inside flag and loads centre 0, radius 65536.
module circle_boundary_projection_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic                last_point_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  new_x_o,
  output logic signed [31:0]  new_y_o,
  output logic                moved_o,
  output logic                population_inside_o,
  output logic                end_of_population_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [cbp_pkg::AddrW-1:0]    paddr,
  input  logic [cbp_pkg::ApbDataW-1:0] pwdata,
  output logic [cbp_pkg::ApbDataW-1:0] prdata,
  output logic                pready
);
  import cbp_pkg::*;

  logic signed [CoordW-1:0] centre_x_q, centre_y_q;
  logic [RadiusW-1:0]       radius_q;
  reg_idx_e                 reg_idx;
  logic                     wr_en;
  cmd_t                     cmd;
  stat_t                    stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= CentreReset;
      centre_y_q <= CentreReset;
      radius_q   <= RadiusReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTRE_X: centre_x_q <= pwdata;
        REG_CENTRE_Y: centre_y_q <= pwdata;
        REG_RADIUS:   radius_q   <= pwdata[RadiusW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTRE_X: prdata = centre_x_q;
      REG_CENTRE_Y: prdata = centre_y_q;
      REG_RADIUS:   prdata = ApbDataW'(radius_q);
      default:      prdata = '0;
    endcase
  end

  cbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cbp_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .centre_x_i          (centre_x_q),
    .centre_y_i          (centre_y_q),
    .circle_radius_i     (radius_q),
    .point_x_i           (point_x_i),
    .point_y_i           (point_y_i),
    .last_point_i        (last_point_i),
    .new_x_o             (new_x_o),
    .new_y_o             (new_y_o),
    .moved_o             (moved_o),
    .population_inside_o (population_inside_o),
    .end_of_population_o (end_of_population_o),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i)
  );

endmodule

### rtl/cbp_checker.sv
// Port-level checks for the disk clamp, bound to the top level.
module cbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] new_x_o,
  input logic [31:0] new_y_o,
  input logic        moved_o,
  input logic        population_inside_o,
  input logic        end_of_population_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_x_o) && $stable(new_y_o)
      && $stable(moved_o) && $stable(end_of_population_o))
    else $error("result changed while stalled");

  // the population verdict only comes with the last item
  a_verdict_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && population_inside_o |-> end_of_population_o)
    else $error("population_inside without end_of_population");

  // a projected point cannot close an all-inside population
  a_verdict_vs_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && population_inside_o |-> !moved_o)
    else $error("population_inside with moved point");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

endmodule

bind circle_boundary_projection_top cbp_checker u_cbp_checker (.*);
